[sv/io_register_file_with_joypad_unit_defines.svh]
// ----------------------------------------------------------------------------
// I/O register file assertion macros
// Concurrent assertion wrappers, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef IO_REGISTER_FILE_WITH_JOYPAD_UNIT_DEFINES_SVH
`define IO_REGISTER_FILE_WITH_JOYPAD_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define IORF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("iorf assertion failed");
`define IORF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("iorf assertion failed");
`else
`define IORF_ASSERT_IMP(label, clk, rst, ante, cons)
`define IORF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[sv/iorf_pkg.sv]
// ----------------------------------------------------------------------------
// I/O register file package
// Event kinds, register attributes, power-on values and bit masks.
// ----------------------------------------------------------------------------
package iorf_pkg;

   localparam int         MAPPED_SPAN = 76;
   localparam logic [7:0] IO_PAGE     = 8'hFF;

   localparam logic [6:0] OFF_JOYP  = 7'h00;
   localparam logic [6:0] OFF_SDATA = 7'h01;
   localparam logic [6:0] OFF_IF    = 7'h0F;

   localparam logic [7:0] JOYP_SEL     = 8'h30;
   localparam logic [7:0] JOYP_KEEP    = 8'hCF;
   localparam logic [7:0] JOYP_HIGH    = 8'hC0;
   localparam logic [7:0] STAT_WR      = 8'h78;
   localparam logic [7:0] STAT_KEEP    = 8'h07;
   localparam logic [7:0] SERIAL_START = 8'h81;
   localparam logic [7:0] IF_JOYPAD    = 8'h10;
   localparam logic [7:0] BYTE_ONES    = 8'hFF;

   typedef enum logic [1:0] {
      KIND_READ    = 2'd0,
      KIND_WRITE   = 2'd1,
      KIND_PRESS   = 2'd2,
      KIND_RELEASE = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ATTR_NONE  = 3'd0,
      ATTR_PLAIN = 3'd1,
      ATTR_JOYP  = 3'd2,
      ATTR_SCTL  = 3'd3,
      ATTR_TIMER = 3'd4,
      ATTR_STAT  = 3'd5,
      ATTR_LY    = 3'd6,
      ATTR_DMA   = 3'd7
   } attr_type;

   function automatic attr_type slot_attr(input logic [6:0] off);
      attr_type a;
      case (off)
         7'h00: a = ATTR_JOYP;
         7'h02: a = ATTR_SCTL;
         7'h04, 7'h05, 7'h06, 7'h07: a = ATTR_TIMER;
         7'h41: a = ATTR_STAT;
         7'h44: a = ATTR_LY;
         7'h46: a = ATTR_DMA;
         7'h01, 7'h0F, 7'h10, 7'h11, 7'h12, 7'h14, 7'h16, 7'h17, 7'h19, 7'h1A,
         7'h1B, 7'h1C, 7'h1E, 7'h20, 7'h21, 7'h22, 7'h23, 7'h24, 7'h25, 7'h26,
         7'h40, 7'h42, 7'h43, 7'h45, 7'h47, 7'h48, 7'h49, 7'h4A, 7'h4B:
            a = ATTR_PLAIN;
         default: a = ATTR_NONE;
      endcase
      return a;
   endfunction

   function automatic logic [7:0] slot_init(input logic [6:0] off);
      logic [7:0] v;
      case (off)
         7'h00: v = 8'hCF;
         7'h02: v = 8'h7E;
         7'h0F: v = 8'hE1;
         7'h10: v = 8'h80;
         7'h11, 7'h14, 7'h19, 7'h1E, 7'h23: v = 8'hBF;
         7'h12, 7'h25: v = 8'hF3;
         7'h16: v = 8'h3F;
         7'h1A: v = 8'h7F;
         7'h1B, 7'h20, 7'h46, 7'h48, 7'h49: v = 8'hFF;
         7'h1C: v = 8'h9F;
         7'h24: v = 8'h77;
         7'h26: v = 8'hF1;
         7'h40: v = 8'h91;
         7'h41: v = 8'h85;
         7'h47: v = 8'hFC;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

endpackage

[sv/iorf_channels.sv]
// ----------------------------------------------------------------------------
// I/O register file channels
// Valid/ready channels for event words and result words.
// ----------------------------------------------------------------------------
interface iorf_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] address;
   logic [7:0]  write_data;
   logic [2:0]  button;

   modport source (output valid, kind, address, write_data, button, input ready);
   modport sink   (input valid, kind, address, write_data, button, output ready);
endinterface

interface iorf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       serial_valid;
   logic [7:0] serial_char;
   logic       dma_kick;
   logic       timer_access;

   modport source (output valid, read_data, serial_valid, serial_char, dma_kick,
                   timer_access, input ready);
   modport sink   (input valid, read_data, serial_valid, serial_char, dma_kick,
                   timer_access, output ready);
endinterface

[sv/iorf_ram.sv]
// ----------------------------------------------------------------------------
// I/O register file RAM
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module iorf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/io_register_file_with_joypad_unit.sv]
// ----------------------------------------------------------------------------
// I/O register file with joypad
// Mapped register store with write masks, serial/DMA side effects and joypad.
// ----------------------------------------------------------------------------
// Words pass stage 1, then the result register; one word per cycle unless the
// result channel stalls. One RAM read at accept, write-back as the word leaves
// stage 1, with forwarding when the write-back and the next read hit the same
// entry. Reset: synchronous; ready the cycle after reset, no clearing pass.
// Per-entry valid bits return power-on values until an entry is first written.
module io_register_file_with_joypad_unit
   import iorf_pkg::*;
#(
   parameter int REGISTER_SLOTS = 128
) (
   input logic         clock,
   input logic         reset,
   iorf_req_if.sink    req_chan,
   iorf_rsp_if.source  rsp_chan
);

`include "io_register_file_with_joypad_unit_defines.svh"

   localparam int ADDR_W = $clog2(REGISTER_SLOTS);

   typedef struct packed {
      kind_type   kind;
      attr_type   attr;
      logic [6:0] off;
      logic [7:0] data;
      logic [2:0] button;
   } stage_type;

   // stage 1
   logic       s1_valid_ff, s1_valid_in;
   stage_type  s1_ff, s1_in;
   logic       fwd_ff, fwd_in;
   logic [7:0] fwd_data_ff;
   logic       vld_ff;
   logic [7:0] init_ff;
   logic [MAPPED_SPAN-1:0] entry_valid_ff;
   logic [7:0] button_mask_ff, button_mask_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_read_data_ff;
   logic       rsp_serial_valid_ff;
   logic [7:0] rsp_serial_char_ff;
   logic       rsp_dma_kick_ff;
   logic       rsp_timer_access_ff;

   logic       accept, advance, mapped;
   logic [6:0] req_off, rd_off, wr_off;
   logic [7:0] ram_rd_data, cur, wdata, nib;
   logic       ram_we;
   logic [7:0] rd_byte, schar;
   logic       sval, dma, tacc;

   assign advance  = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !reset && (!s1_valid_ff || advance);
   assign accept   = req_chan.valid && req_chan.ready;

   // decode
   assign mapped  = (req_chan.address[15:8] == IO_PAGE) &&
                    (req_chan.address[7:0] < 8'(MAPPED_SPAN));
   assign req_off = mapped ? req_chan.address[6:0] : OFF_JOYP;

   always_comb begin
      s1_in.kind   = kind_type'(req_chan.kind);
      s1_in.attr   = mapped ? slot_attr(req_off) : ATTR_NONE;
      s1_in.off    = req_off;
      s1_in.data   = req_chan.write_data;
      s1_in.button = req_chan.button;
      rd_off       = req_off;
      if (s1_in.kind == KIND_PRESS) begin
         rd_off = OFF_IF;
      end else if (s1_in.kind == KIND_WRITE && s1_in.attr == ATTR_SCTL) begin
         rd_off = OFF_SDATA;
      end
   end

   iorf_ram #(
      .WIDTH (8),
      .DEPTH (REGISTER_SLOTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ADDR_W'(wr_off)),
      .wr_data (wdata),
      .rd_en   (accept),
      .rd_addr (ADDR_W'(rd_off)),
      .rd_data (ram_rd_data)
   );

   // execute and write back
   assign cur    = fwd_ff ? fwd_data_ff : (vld_ff ? ram_rd_data : init_ff);
   assign wr_off = (s1_ff.kind == KIND_PRESS) ? OFF_IF : s1_ff.off;

   always_comb begin
      nib = 8'h0F;
      if (!cur[4]) begin
         nib = nib & ~{4'h0, button_mask_ff[3:0]};
      end
      if (!cur[5]) begin
         nib = nib & ~{4'h0, button_mask_ff[7:4]};
      end
   end

   always_comb begin
      rd_byte        = BYTE_ONES;
      sval           = 1'b0;
      schar          = 8'h00;
      dma            = 1'b0;
      tacc           = 1'b0;
      ram_we         = 1'b0;
      wdata          = s1_ff.data;
      button_mask_in = button_mask_ff;
      case (s1_ff.kind)
         KIND_READ: begin
            case (s1_ff.attr)
               ATTR_JOYP:  rd_byte = JOYP_HIGH | (cur & JOYP_SEL) | nib;
               ATTR_TIMER: tacc = 1'b1;
               ATTR_NONE:  rd_byte = BYTE_ONES;
               default:    rd_byte = cur;
            endcase
         end
         KIND_WRITE: begin
            case (s1_ff.attr)
               ATTR_JOYP: begin
                  ram_we = 1'b1;
                  wdata  = (cur & JOYP_KEEP) | (s1_ff.data & JOYP_SEL);
               end
               ATTR_SCTL: begin
                  ram_we = 1'b1;
                  if (s1_ff.data == SERIAL_START) begin
                     sval  = 1'b1;
                     schar = cur;
                     wdata = 8'h00;
                  end
               end
               ATTR_TIMER: tacc = 1'b1;
               ATTR_STAT: begin
                  ram_we = 1'b1;
                  wdata  = (cur & STAT_KEEP) | (s1_ff.data & STAT_WR);
               end
               ATTR_DMA: begin
                  ram_we  = 1'b1;
                  dma     = 1'b1;
                  rd_byte = s1_ff.data;
               end
               ATTR_PLAIN: ram_we = 1'b1;
               default:    ram_we = 1'b0;
            endcase
         end
         KIND_PRESS: begin
            ram_we         = 1'b1;
            wdata          = cur | IF_JOYPAD;
            button_mask_in = button_mask_ff | (8'd1 << s1_ff.button);
         end
         default: begin
            button_mask_in = button_mask_ff & ~(8'd1 << s1_ff.button);
         end
      endcase
      if (!advance) begin
         ram_we         = 1'b0;
         button_mask_in = button_mask_ff;
      end
   end

   assign fwd_in       = ram_we && (wr_off == rd_off);
   assign s1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         fwd_ff         <= 1'b0;
         entry_valid_ff <= '0;
         button_mask_ff <= 8'h00;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         button_mask_ff <= button_mask_in;
         if (accept) begin
            fwd_ff <= fwd_in;
         end
         if (ram_we) begin
            entry_valid_ff[wr_off] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff       <= s1_in;
         fwd_data_ff <= wdata;
         vld_ff      <= entry_valid_ff[rd_off];
         init_ff     <= slot_init(rd_off);
      end
      if (advance) begin
         rsp_read_data_ff    <= rd_byte;
         rsp_serial_valid_ff <= sval;
         rsp_serial_char_ff  <= schar;
         rsp_dma_kick_ff     <= dma;
         rsp_timer_access_ff <= tacc;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.read_data    = rsp_read_data_ff;
   assign rsp_chan.serial_valid = rsp_serial_valid_ff;
   assign rsp_chan.serial_char  = rsp_serial_char_ff;
   assign rsp_chan.dma_kick     = rsp_dma_kick_ff;
   assign rsp_chan.timer_access = rsp_timer_access_ff;

   `IORF_ASSERT_NEXT(a_accept_loads, clock, reset, accept, s1_valid_ff)
   `IORF_ASSERT_NEXT(a_advance_shows, clock, reset, advance, rsp_valid_ff)
   `IORF_ASSERT_NEXT(a_stall_holds, clock, reset, s1_valid_ff && !advance, s1_valid_ff)
   `IORF_ASSERT_IMP(a_serial_excl, clock, reset, advance && sval, !dma && !tacc)

endmodule
